>>> rtl/core/lac_pkg.sv
// ----------------------------------------------------------------------------
// Lagged autocorrelation package
// Field widths, status codes and configuration register indexes shared by
// the core, its divider and its checker.
// ----------------------------------------------------------------------------
package lac_pkg;

  localparam int Q15_W   = 16;
  localparam int LAG_W   = 6;
  localparam int VAL_W   = 32;
  localparam int STAT_W  = 2;
  localparam int LAGC_W  = 7;
  localparam int CFG_A_W = 8;
  localparam int CFG_D_W = 8;

  typedef logic [STAT_W-1:0]  status_t;
  typedef logic [CFG_A_W-1:0] cfg_idx_t;

  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_LAGS = 2'd1;
  localparam status_t ST_OVFL = 2'd2;

  localparam cfg_idx_t CFG_LAG_COUNT = 8'd0;
  localparam cfg_idx_t CFG_CIRCULAR  = 8'd1;

endpackage

>>> rtl/core/lac_div.sv
// ----------------------------------------------------------------------------
// Lagged autocorrelation divider
// Restoring divider of a signed sum by an unsigned term count, one quotient
// bit per cycle, with the quotient truncated toward zero.
// ----------------------------------------------------------------------------
module lac_div
  import lac_pkg::*;
#(
  parameter int ACC_W = 43,
  parameter int DIV_W = 11
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    div_start,
  input  logic signed [ACC_W-1:0] dividend,
  input  logic        [DIV_W-1:0] divisor,
  output logic                    div_done,
  output logic signed [VAL_W-1:0] quotient
);

  localparam int CNT_W = $clog2(ACC_W + 1);

  logic             busy_r,  busy_nxt;
  logic             done_r,  done_nxt;
  logic [CNT_W-1:0] cnt_r,   cnt_nxt;
  logic [DIV_W:0]   rem_r,   rem_nxt;
  logic [ACC_W-1:0] quo_r,   quo_nxt;
  logic             neg_r,   neg_nxt;
  logic [DIV_W:0]   trial;
  logic [ACC_W-1:0] mag;
  logic [ACC_W-1:0] quo_neg;

  always_comb begin
    mag      = dividend[ACC_W-1] ? (ACC_W'(0) - dividend) : dividend;
    trial    = {rem_r[DIV_W-1:0], quo_r[ACC_W-1]};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    neg_nxt  = neg_r;
    if (div_start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(ACC_W);
      rem_nxt  = '0;
      quo_nxt  = mag;
      neg_nxt  = dividend[ACC_W-1];
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = trial - {1'b0, divisor};
        quo_nxt = {quo_r[ACC_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[ACC_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    neg_r <= neg_nxt;
  end

  assign quo_neg  = ACC_W'(0) - quo_r;
  assign div_done = done_r;
  assign quotient = neg_r ? $signed(quo_neg[VAL_W-1:0]) : $signed(quo_r[VAL_W-1:0]);

endmodule

>>> rtl/core/lagged_autocorrelation.sv
// ----------------------------------------------------------------------------
// Lagged autocorrelation core
// Stores a series of samples, then produces its autocorrelation for each
// lag with one shared multiply-accumulate unit and a serial divider.
//
// Channel  Ports                                      Beat taken when
// input    start, busy, in_sample, in_last            start & !busy
// result   out_valid, out_lag, out_value, out_status,  out_valid
//          out_final_res
// config   cfg_valid, cfg_ready, cfg_index, cfg_data  cfg_valid & cfg_ready
//
// After the last sample, each lag runs its multiply-accumulate through the
// two-port sample store and then the serial divider, both ACC_W bits wide,
// ACC_W being 32 plus the width of the sample count. An error run gives its
// single result from the check state that the last sample moves the core to.
// Reset clears the count and flags; the store needs no clearing. Results
// are shown for one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module lagged_autocorrelation
  import lac_pkg::*;
#(
  parameter int MAX_SAMPLES = 1024,
  parameter int MAX_LAGS    = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                         in_last,
  output logic                         out_valid,
  output logic        [LAG_W-1:0]      out_lag,
  output logic signed [VAL_W-1:0]      out_value,
  output logic        [STAT_W-1:0]     out_status,
  output logic                         out_final_res,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic        [CFG_A_W-1:0]    cfg_index,
  input  logic        [CFG_D_W-1:0]    cfg_data
);

  localparam int AW    = $clog2(MAX_SAMPLES);
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int ACC_W = 32 + CNT_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_MAC   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;

  localparam logic [LAGC_W-1:0] MAX_LAGS_C = LAGC_W'(MAX_LAGS);
  localparam logic [CNT_W-1:0]  MAX_CNT    = CNT_W'(MAX_SAMPLES);

  logic signed [Q15_W-1:0] store_mem [MAX_SAMPLES];

  logic [2:0]              state_r,    state_nxt;
  logic [LAGC_W-1:0]       lagc_r,     lagc_nxt;
  logic                    circ_r,     circ_nxt;
  logic [CNT_W-1:0]        count_r,    count_nxt;
  logic                    ovfl_r,     ovfl_nxt;
  logic [LAG_W-1:0]        lag_r,      lag_nxt;
  logic [CNT_W-1:0]        j_r,        j_nxt;
  logic [AW-1:0]           idx_r,      idx_nxt;
  logic [CNT_W-1:0]        terms_r,    terms_nxt;
  logic                    rd_v_r,     rd_v_nxt;
  logic                    mul_v_r,    mul_v_nxt;
  logic signed [ACC_W-1:0] acc_r,      acc_nxt;
  logic                    ov_r,       ov_nxt;
  logic [LAG_W-1:0]        olag_r,     olag_nxt;
  logic signed [VAL_W-1:0] oval_r,     oval_nxt;
  logic [STAT_W-1:0]       ostat_r,    ostat_nxt;
  logic                    ofin_r,     ofin_nxt;
  logic signed [Q15_W-1:0] rd_a_r,     rd_b_r;
  logic signed [31:0]      prod_r;

  logic                    accept;
  logic                    wr_en;
  logic signed [Q15_W-1:0] q15;
  logic [LAGC_W-1:0]       lags_sat;
  logic [CNT_W-1:0]        lag_ext;
  logic [CNT_W-1:0]        lag_inc;
  logic [LAGC_W-1:0]       lag_cmp;
  logic                    div_start;
  logic                    div_done;
  logic signed [VAL_W-1:0] div_quot;

  generate
    if (SAMPLE_BITS >= Q15_W) begin : g_narrow
      logic signed [SAMPLE_BITS-1:0] shifted;
      assign shifted = in_sample >>> (SAMPLE_BITS - Q15_W);
      assign q15     = shifted[Q15_W-1:0];
    end else begin : g_widen
      assign q15 = {in_sample, {(Q15_W - SAMPLE_BITS){1'b0}}};
    end
  endgenerate

  assign accept    = start && !busy;
  assign wr_en     = accept && (count_r < MAX_CNT);
  assign lags_sat  = (lagc_r > MAX_LAGS_C) ? MAX_LAGS_C : lagc_r;
  assign lag_ext   = CNT_W'(lag_r);
  assign lag_inc   = lag_ext + CNT_W'(1);
  assign lag_cmp   = LAGC_W'(lag_r) + LAGC_W'(1);
  assign div_start = (state_r == S_DRAIN) && !rd_v_r && !mul_v_r;

  always_comb begin
    state_nxt = state_r;
    lagc_nxt  = lagc_r;
    circ_nxt  = circ_r;
    count_nxt = count_r;
    ovfl_nxt  = ovfl_r;
    lag_nxt   = lag_r;
    j_nxt     = j_r;
    idx_nxt   = idx_r;
    terms_nxt = terms_r;
    rd_v_nxt  = 1'b0;
    mul_v_nxt = rd_v_r;
    acc_nxt   = mul_v_r ? (acc_r + ACC_W'(prod_r)) : acc_r;
    ov_nxt    = 1'b0;
    olag_nxt  = olag_r;
    oval_nxt  = oval_r;
    ostat_nxt = ostat_r;
    ofin_nxt  = ofin_r;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LAG_COUNT: lagc_nxt = cfg_data[LAGC_W-1:0];
        CFG_CIRCULAR:  circ_nxt = cfg_data[0];
        default:       ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (wr_en) begin
            count_nxt = count_r + CNT_W'(1);
          end else begin
            ovfl_nxt = 1'b1;
          end
          if (in_last) begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (ovfl_r || lags_sat == '0 ||
            CNT_W'(lags_sat) > count_r || lags_sat > LAGC_W'(count_r) &&
            CNT_W < LAGC_W) begin
          ov_nxt    = 1'b1;
          olag_nxt  = '0;
          oval_nxt  = '0;
          ostat_nxt = ovfl_r ? ST_OVFL : ST_LAGS;
          ofin_nxt  = 1'b1;
          count_nxt = '0;
          ovfl_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          lag_nxt   = '0;
          j_nxt     = '0;
          idx_nxt   = '0;
          terms_nxt = count_r;
          acc_nxt   = '0;
          state_nxt = S_MAC;
        end
      end
      S_MAC: begin
        rd_v_nxt = 1'b1;
        j_nxt    = j_r + CNT_W'(1);
        if (CNT_W'(idx_r) + CNT_W'(1) == count_r) begin
          idx_nxt = '0;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
        if (j_r + CNT_W'(1) == terms_r) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (div_start) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          ov_nxt    = 1'b1;
          olag_nxt  = lag_r;
          oval_nxt  = div_quot;
          ostat_nxt = ST_OK;
          ofin_nxt  = (lag_cmp == lags_sat);
          if (lag_cmp == lags_sat) begin
            count_nxt = '0;
            ovfl_nxt  = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            lag_nxt   = lag_r + LAG_W'(1);
            j_nxt     = '0;
            idx_nxt   = AW'(lag_inc);
            terms_nxt = circ_r ? count_r : (count_r - lag_inc);
            acc_nxt   = '0;
            state_nxt = S_MAC;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      lagc_r  <= LAGC_W'(1);
      circ_r  <= 1'b0;
      count_r <= '0;
      ovfl_r  <= 1'b0;
      rd_v_r  <= 1'b0;
      mul_v_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      lagc_r  <= lagc_nxt;
      circ_r  <= circ_nxt;
      count_r <= count_nxt;
      ovfl_r  <= ovfl_nxt;
      rd_v_r  <= rd_v_nxt;
      mul_v_r <= mul_v_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lag_r   <= lag_nxt;
    j_r     <= j_nxt;
    idx_r   <= idx_nxt;
    terms_r <= terms_nxt;
    acc_r   <= acc_nxt;
    olag_r  <= olag_nxt;
    oval_r  <= oval_nxt;
    ostat_r <= ostat_nxt;
    ofin_r  <= ofin_nxt;
    prod_r  <= rd_a_r * rd_b_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[count_r[AW-1:0]] <= q15;
    end
    rd_a_r <= store_mem[j_r[AW-1:0]];
    rd_b_r <= store_mem[idx_r];
  end

  lac_div #(
    .ACC_W (ACC_W),
    .DIV_W (CNT_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .div_start (div_start),
    .dividend  (acc_r),
    .divisor   (terms_r),
    .div_done  (div_done),
    .quotient  (div_quot)
  );

  assign busy          = (state_r != S_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_valid     = ov_r;
  assign out_lag       = olag_r;
  assign out_value     = oval_r;
  assign out_status    = ostat_r;
  assign out_final_res = ofin_r;

endmodule

>>> rtl/core/lac_chk.sv
// ----------------------------------------------------------------------------
// Lagged autocorrelation checker
// Port-level properties of the core's sequencing, bound to the top level.
// ----------------------------------------------------------------------------
module lac_chk
  import lac_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              in_last,
  input logic              out_valid,
  input logic [LAG_W-1:0]  out_lag,
  input logic [VAL_W-1:0]  out_value,
  input logic [STAT_W-1:0] out_status,
  input logic              out_final_res
);

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_final_res && out_lag == '0 && out_value == '0)
    else $error("error result is not a lone final beat");

  a_no_res_mid: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_last |=> !out_valid)
    else $error("result after a sample that was not last");

  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_last |=> busy)
    else $error("core not busy after the last sample");

  a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_final_res |=> busy)
    else $error("core went idle before the final result");

  a_final_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_final_res |=> !out_valid)
    else $error("result beat after the final one");

endmodule

bind lagged_autocorrelation lac_chk u_lac_chk (.*);
